// ----- src/er5_pkg.sv -----
// er5_pkg: types, kernel coefficients and arithmetic constants for the 5x5 relief filter.
// No dependencies. Used by er5_relief and emboss_relief_5x5_core.
package er5_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int KSIZE = 5;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_ROWS = 1'b0,
    REG_IMAGE_COLS = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // sum of the weighted window lies in -5610..5610
  localparam int SUM_W = 14;
  localparam int ABS_W = 13;
  // x / 50 == (x * 20972) >> 20 for 0 <= x <= 5610
  localparam int RECIP_W = 15;
  localparam logic [RECIP_W-1:0] RECIP_50 = 15'd20972;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W = ABS_W + RECIP_W;
  localparam logic [PIX_W-1:0] RELIEF_MID = 8'd128;

  typedef logic signed [2:0] coef_t;
  localparam coef_t KERN [KSIZE][KSIZE] = '{
    '{-3'sd3, -3'sd3, -3'sd2, -3'sd1,  3'sd0},
    '{-3'sd3, -3'sd3, -3'sd2,  3'sd0,  3'sd1},
    '{-3'sd2, -3'sd2,  3'sd0,  3'sd2,  3'sd2},
    '{-3'sd1,  3'sd0,  3'sd2,  3'sd3,  3'sd3},
    '{ 3'sd0,  3'sd1,  3'sd2,  3'sd3,  3'sd3}
  };

  typedef logic [KSIZE-1:0][PIX_W-1:0] win_row_t;
  typedef win_row_t [KSIZE-1:0] win_t;  // win[row][col], col 4 newest

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  // weighted sum of one window row
  function automatic logic signed [SUM_W-1:0] row_sum(input int k, input win_row_t px);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] coef;
    logic signed [SUM_W-1:0] val;
    acc = '0;
    for (int m = 0; m < KSIZE; m++) begin
      coef = SUM_W'(KERN[k][m]);
      val = SUM_W'({1'b0, px[m]});
      acc = acc + coef * val;
    end
    return acc;
  endfunction

endpackage

// ----- src/er5_ram.sv -----
// er5_ram: generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module er5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/er5_relief.sv -----
// er5_relief: kernel sum over the 5x5 window, divide by 50 and offset, three register stages.
// Depends on er5_pkg.
module er5_relief (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  er5_pkg::tag_t         in_tag,
  input  er5_pkg::win_t         win,
  output er5_pkg::tag_t         out_tag,
  output logic [7:0]            relief
);
  import er5_pkg::*;

  logic signed [SUM_W-1:0] rsum [KSIZE];
  tag_t                    a_tag;
  logic signed [SUM_W-1:0] total;
  tag_t                    b_tag;
  logic                    b_neg;
  logic [ABS_W-1:0]        b_abs;
  tag_t                    c_tag;
  logic                    c_neg;
  logic [PROD_W-1:0]       c_prod;
  logic [PIX_W-1:0]        quot;

  always_comb begin
    total = '0;
    for (int k = 0; k < KSIZE; k++) begin
      total = total + rsum[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
      b_tag <= '0;
      c_tag <= '0;
    end else if (en) begin
      a_tag <= in_tag;
      b_tag <= a_tag;
      c_tag <= b_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < KSIZE; k++) begin
        rsum[k] <= row_sum(k, win[k]);
      end
      b_neg  <= total[SUM_W-1];
      b_abs  <= total[SUM_W-1] ? ABS_W'(-total) : ABS_W'(total);
      c_neg  <= b_neg;
      c_prod <= PROD_W'(b_abs) * PROD_W'(RECIP_50);
    end
  end

  assign quot    = PIX_W'(c_prod >> RECIP_SHIFT);
  assign out_tag = c_tag;
  // truncation toward zero: negative sum raises the output
  assign relief  = c_neg ? (RELIEF_MID + quot) : (RELIEF_MID - quot);

endmodule

// ----- src/emboss_relief_5x5_core.sv -----
// 5x5 emboss filter over a raster stream padded by two rows and two columns.
// Path: stage 1 registers, window and tag registers, the relief stages, then the output register.
// Throughput: one pixel per cycle while the skid is empty, set by the single line-store read per pixel.
// A two-entry output stage (register plus skid) lets input continue while a result waits.
// Reset (synchronous): sizes to 1024x1024, frame position to (0,0), pipeline empty; the
// line store holds no reset and is masked by position, so no clearing pass is needed.
module emboss_relief_5x5_core #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] relief
  output logic                              m_axis_tlast,
  input  logic                              cfg_wr_en,
  input  logic [er5_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [er5_pkg::CFG_W-1:0]         cfg_data
);
  import er5_pkg::*;

  localparam int LINE_W = MAX_COLS + 2;
  localparam int CW = $clog2(LINE_W);
  localparam int RW = $clog2(MAX_ROWS + 6);
  localparam int LINE_BITS = (KSIZE - 1) * PIX_W;

  logic [CFG_W-1:0]      image_rows;
  logic [CFG_W-1:0]      image_cols;
  logic [RW-1:0]         rows_eff;
  logic [CW-1:0]         cols_eff;

  logic [RW-1:0]         row_pos;
  logic [CW-1:0]         col_pos;
  logic                  adv;
  logic                  accept;
  logic                  row_end;
  logic [KSIZE-1:0]      rmask;

  logic                  s1_valid;
  logic                  s1_emit;
  logic                  s1_last;
  logic [KSIZE-1:0]      s1_rmask;
  logic                  s1_cok;
  logic [CW-1:0]         s1_col;
  logic [PIX_W-1:0]      s1_pixel;
  logic [LINE_BITS-1:0]  line_rd;
  logic [LINE_BITS-1:0]  line_wr;
  logic [KSIZE-1:0][PIX_W-1:0] column;

  win_t                  win;
  tag_t                  s2_tag;
  tag_t                  res_tag;
  logic [PIX_W-1:0]      res_relief;

  logic                  out_valid;
  logic                  skid_valid;
  logic [PIX_W-1:0]      out_relief;
  logic                  out_last;
  logic [PIX_W-1:0]      skid_relief;
  logic                  skid_last;

  // size registers, zero read as one, clipped to the maxima
  always_comb begin
    if (image_rows == '0) begin
      rows_eff = RW'(1);
    end else if (32'(image_rows) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(image_rows);
    end
    if (image_cols == '0) begin
      cols_eff = CW'(1);
    end else if (32'(image_cols) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(image_cols);
    end
  end

  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign row_end       = (col_pos == cols_eff + CW'(1));

  // rows r-4..r of the column that this pixel completes, inside the image or not
  always_comb begin
    for (int k = 0; k < KSIZE; k++) begin
      rmask[k] = (row_pos + RW'(k) >= RW'(KSIZE - 1)) &&
                 (row_pos + RW'(k) < rows_eff + RW'(KSIZE - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= SIZE_RESET;
      image_cols <= SIZE_RESET;
      row_pos    <= '0;
      col_pos    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_ROWS: image_rows <= cfg_data;
        REG_IMAGE_COLS: image_cols <= cfg_data;
        default: ;
      endcase
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= (row_pos == rows_eff + RW'(1)) ? '0 : row_pos + RW'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  // line store: one entry per column holds the four rows above; consecutive transactions
  // always touch different columns, so the write-back never meets a pending read
  er5_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (LINE_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (adv && s1_valid),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_en   (adv),
    .rd_addr (col_pos),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit  <= (row_pos >= RW'(2)) && (col_pos >= CW'(2));
      s1_last  <= (row_pos == rows_eff + RW'(1)) && row_end;
      s1_rmask <= rmask;
      s1_cok   <= (col_pos < cols_eff);
      s1_col   <= col_pos;
      s1_pixel <= s_axis_tdata;
    end
  end

  always_comb begin
    for (int k = 0; k < KSIZE - 1; k++) begin
      column[k] = line_rd[k*PIX_W +: PIX_W];
    end
    column[KSIZE-1] = s1_pixel;
    for (int k = 0; k < KSIZE - 1; k++) begin
      line_wr[k*PIX_W +: PIX_W] = column[k+1];
    end
  end

  // window shift; out-of-image entries enter as zero
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      for (int k = 0; k < KSIZE; k++) begin
        for (int m = 0; m < KSIZE - 1; m++) begin
          win[k][m] <= win[k][m+1];
        end
        win[k][KSIZE-1] <= (s1_rmask[k] && s1_cok) ? column[k] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else if (adv) begin
      s2_tag.valid <= s1_valid && s1_emit;
      s2_tag.last  <= s1_last;
    end
  end

  er5_relief u_relief (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_tag  (s2_tag),
    .win     (win),
    .out_tag (res_tag),
    .relief  (res_relief)
  );

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (adv) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= res_tag.valid;
      end else if (res_tag.valid) begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!out_valid || m_axis_tready) begin
        out_relief <= res_relief;
        out_last   <= res_tag.last;
      end else begin
        skid_relief <= res_relief;
        skid_last   <= res_tag.last;
      end
    end else if (m_axis_tready) begin
      out_relief <= skid_relief;
      out_last   <= skid_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_relief;
  assign m_axis_tlast  = out_last;

endmodule
